### rtl/core/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and codes of the transmit slot manager
// Commands, slot states, engine states, actions, config register indices, payload structs and controller links.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam logic [2:0] CMD_RESERVE = 3'd0;
    localparam logic [2:0] CMD_PUSH    = 3'd1;
    localparam logic [2:0] CMD_READ    = 3'd2;
    localparam logic [2:0] CMD_PEEK    = 3'd3;
    localparam logic [2:0] CMD_CANCEL  = 3'd4;
    localparam logic [2:0] CMD_HOLD    = 3'd5;
    localparam logic [2:0] CMD_DELAY   = 3'd6;
    localparam logic [2:0] CMD_TICK    = 3'd7;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RESERVED = 3'd1;
    localparam logic [2:0] ST_PENDING  = 3'd2;
    localparam logic [2:0] ST_SENDING  = 3'd3;
    localparam logic [2:0] ST_OKAY     = 3'd4;
    localparam logic [2:0] ST_FAIL     = 3'd5;

    localparam logic [1:0] EN_IDLE = 2'd0;
    localparam logic [1:0] EN_BODY = 2'd1;
    localparam logic [1:0] EN_EOP  = 2'd2;
    localparam logic [1:0] EN_GAP  = 2'd3;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_BYTE  = 3'd2;
    localparam logic [2:0] ACT_EOP   = 3'd3;
    localparam logic [2:0] ACT_OK    = 3'd4;
    localparam logic [2:0] ACT_FAIL  = 3'd5;

    localparam logic [2:0] REG_MAX_LEN   = 3'd0;
    localparam logic [2:0] REG_MAX_DELAY = 3'd1;
    localparam logic [2:0] REG_PHASES    = 3'd2;
    localparam logic [2:0] REG_WATCHDOG  = 3'd3;
    localparam logic [2:0] REG_SCAN_GAP  = 3'd4;
    localparam logic [2:0] REG_MAX_NAV   = 3'd5;

    localparam int CFG_W = 16;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  slot;
        logic [2:0]  phase;
        logic [7:0]  xmode;
        logic        scan;
        logic [15:0] delay;
        logic [9:0]  frame_len;
        logic        hold;
        logic [15:0] resv_time;
        logic        tx_byte_taken;
        logic        tx_buf_expired;
        logic        tx_end_done;
    } req_t;

    typedef struct packed {
        logic        ack_ok;
        logic [3:0]  slot_id;
        logic [2:0]  slot_state;
        logic [2:0]  tx_action;
        logic [2:0]  tx_phase;
        logic [7:0]  tx_ctrl;
        logic [9:0]  byte_index;
        logic [11:0] resv_units;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture request, age delays on tick
        logic exec;    // apply the captured request
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
    } sts_t;

endpackage

### rtl/core/tx_slot_manager_with_dispatch.sv
// ----------------------------------------------------------------------------
// tx_slot_manager_with_dispatch: transmit slot table with dispatch engine
// Command channel in, one response per command out.
// ----------------------------------------------------------------------------
// Usage: present one request on in_* (valid/ready); exactly one response
// comes back on out_* (valid/ready). The accepting edge captures the
// request, and a tick ages slot delays there; the next edge executes it
// against the slot table and transmit engine and loads the output register.
// Response valid rises at the executing edge, together with the output
// register; no new request is taken while one executes. A new request is
// accepted in the same cycle the held response is taken. When the receiver
// stalls, the response holds and no further request is taken. Reset clears
// all slots to idle, the engine to idle and the configuration and output
// registers to their reset values. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module tx_slot_manager_with_dispatch
#(
    parameter int SLOTS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tsm_pkg::req_t              in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tsm_pkg::rsp_t              out_data,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [tsm_pkg::CFG_W-1:0]  cfg_data
);

    tsm_pkg::ctl_t ctl;
    tsm_pkg::sts_t sts;

    tsm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    tsm_datapath #(.SLOTS(SLOTS)) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sts      (sts),
        .req      (in_data),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .rsp      (out_data)
    );

endmodule

### rtl/core/tsm_ctrl.sv
// ----------------------------------------------------------------------------
// tsm_ctrl: request sequencer
// Takes a request, runs the capture and execute steps, holds the response.
// ----------------------------------------------------------------------------
module tsm_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  tsm_pkg::sts_t  sts,
    output tsm_pkg::ctl_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_EXEC;
            S_EXEC: state_next = S_DONE;
            S_DONE: if (out_ready) state_next = in_valid ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // accept a request when idle, or as the held response leaves
    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_DONE && out_ready);
    assign out_valid = (state_reg == S_DONE);
    assign ctl.load  = in_valid && in_ready;
    assign ctl.exec  = (state_reg == S_EXEC);

`ifndef SYNTHESIS
    a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ctl.exec) else $error("exec did not follow load");
    a_no_load_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |-> !ctl.load) else $error("load during exec");
    a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |-> sts.busy) else $error("datapath not busy in exec");
`endif

endmodule

### rtl/core/tsm_datapath.sv
// ----------------------------------------------------------------------------
// tsm_datapath: slot table and transmit engine
// Stage one captures the request and ages delays on tick; stage two executes it.
// ----------------------------------------------------------------------------
module tsm_datapath
#(
    parameter int SLOTS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsm_pkg::ctl_t                   ctl,
    output tsm_pkg::sts_t                   sts,
    input  tsm_pkg::req_t                   req,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_idx,
    input  logic [tsm_pkg::CFG_W-1:0]       cfg_data,
    output tsm_pkg::rsp_t                   rsp
);

    localparam int SW = $clog2(SLOTS);

    logic [9:0]  max_len_reg;
    logic [15:0] max_delay_reg;
    logic [1:0]  phases_reg;
    logic [12:0] wd_limit_reg;
    logic [15:0] scan_gap_reg;
    logic [11:0] max_nav_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= 10'd255;
            max_delay_reg <= 16'hFFFF;
            phases_reg    <= 2'd3;
            wd_limit_reg  <= 13'd5000;
            scan_gap_reg  <= 16'd10;
            max_nav_reg   <= 12'hFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                tsm_pkg::REG_MAX_LEN:   max_len_reg   <= cfg_data[9:0];
                tsm_pkg::REG_MAX_DELAY: max_delay_reg <= cfg_data[15:0];
                tsm_pkg::REG_PHASES:    phases_reg    <= cfg_data[1:0];
                tsm_pkg::REG_WATCHDOG:  wd_limit_reg  <= cfg_data[12:0];
                tsm_pkg::REG_SCAN_GAP:  scan_gap_reg  <= cfg_data[15:0];
                tsm_pkg::REG_MAX_NAV:   max_nav_reg   <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic [2:0]  status_reg [SLOTS];
    logic [2:0]  phase_reg  [SLOTS];
    logic [7:0]  mode_reg   [SLOTS];
    logic        scanf_reg  [SLOTS];
    logic        holdf_reg  [SLOTS];
    logic [15:0] delay_reg  [SLOTS];
    logic [9:0]  len_reg    [SLOTS];
    logic [9:0]  sent_reg   [SLOTS];
    logic [1:0]  order_reg  [SLOTS];
    logic [11:0] nav_reg    [SLOTS];
    logic [1:0]  eng_reg;
    logic [SW-1:0] act_reg;
    // one bit above the limit so the count can pass it
    logic [13:0] wd_reg;
    tsm_pkg::req_t req_reg;
    tsm_pkg::rsp_t rsp_reg;
    tsm_pkg::rsp_t rsp_next;
    logic        busy_reg;

    // stage-two decode
    logic          s_valid;
    logic [SW-1:0] s;
    logic          tick;
    logic [2:0]    st_s;

    assign s_valid = ({4'd0, req_reg.slot} < 8'(SLOTS));
    assign s       = req_reg.slot[SW-1:0];
    assign tick    = (req_reg.cmd == tsm_pkg::CMD_TICK);
    assign st_s    = status_reg[s];

    // reserve search: idle first, then finished
    logic          free_hit, done_hit;
    logic [SW-1:0] free_idx, done_idx;
    logic [SW-1:0] rsv_idx;
    // dispatch search
    logic          due_hit;
    logic [SW-1:0] due_idx;

    always_comb
    begin
        free_hit = 1'b0; done_hit = 1'b0; due_hit = 1'b0;
        free_idx = '0;   done_idx = '0;   due_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (status_reg[i] == tsm_pkg::ST_IDLE)
            begin
                free_hit = 1'b1; free_idx = SW'(i);
            end
            if (status_reg[i] == tsm_pkg::ST_OKAY || status_reg[i] == tsm_pkg::ST_FAIL)
            begin
                done_hit = 1'b1; done_idx = SW'(i);
            end
            if (status_reg[i] == tsm_pkg::ST_PENDING && !holdf_reg[i]
                && delay_reg[i] == 16'd0)
            begin
                due_hit = 1'b1; due_idx = SW'(i);
            end
        end
    end

    assign rsv_idx = free_hit ? free_idx : done_idx;

    // push validation
    logic push_bad;
    assign push_bad = ({1'b0, phases_reg} < req_reg.phase) || (req_reg.xmode[7:4] == 4'd0)
        || (req_reg.xmode[3:0] == 4'h3) || (req_reg.delay > max_delay_reg)
        || (req_reg.frame_len == 10'd0) || (req_reg.frame_len > max_len_reg);

    // hold rounding
    logic [11:0] nav_q;
    logic [11:0] nav_v;
    assign nav_q = req_reg.resv_time[15:4];
    always_comb
    begin
        if (nav_q > max_nav_reg)
            nav_v = max_nav_reg;
        else if (req_reg.resv_time[3:0] != 4'd0 && nav_q < max_nav_reg)
            nav_v = nav_q + 12'd1;
        else
            nav_v = nav_q;
    end

    logic [SW-1:0] a;
    assign a = act_reg;

    logic wd_over;
    logic body_fail;
    logic eop_last;
    assign wd_over   = (wd_reg > {1'b0, wd_limit_reg});
    assign body_fail = req_reg.tx_buf_expired || wd_over;
    assign eop_last  = !scanf_reg[a] || order_reg[a] == 2'd3;

    // response of the captured request
    always_comb
    begin
        rsp_next = '0;
        if (s_valid)
            rsp_next.slot_id = req_reg.slot;
        case (req_reg.cmd)
            tsm_pkg::CMD_RESERVE:
            begin
                if (free_hit || done_hit)
                begin
                    rsp_next.slot_id    = 4'(rsv_idx);
                    rsp_next.ack_ok     = 1'b1;
                    rsp_next.slot_state = tsm_pkg::ST_RESERVED;
                end
                else
                    rsp_next.slot_id = 4'(SLOTS);
            end
            tsm_pkg::CMD_PUSH:
            begin
                if (s_valid && st_s != tsm_pkg::ST_RESERVED)
                    rsp_next.slot_state = st_s;
                else if (s_valid && !push_bad)
                begin
                    rsp_next.ack_ok     = 1'b1;
                    rsp_next.slot_state = tsm_pkg::ST_PENDING;
                end
            end
            tsm_pkg::CMD_READ, tsm_pkg::CMD_PEEK:
            begin
                if (!s_valid)
                    rsp_next.slot_state = tsm_pkg::ST_FAIL;
                else
                begin
                    rsp_next.ack_ok     = 1'b1;
                    rsp_next.slot_state = st_s;
                end
            end
            tsm_pkg::CMD_CANCEL:
            begin
                if (s_valid && st_s == tsm_pkg::ST_PENDING)
                begin
                    rsp_next.ack_ok     = 1'b1;
                    rsp_next.slot_state = tsm_pkg::ST_FAIL;
                end
                else if (s_valid)
                    rsp_next.slot_state = st_s;
            end
            tsm_pkg::CMD_HOLD:
            begin
                if (s_valid)
                    rsp_next.slot_state = st_s;
                if (s_valid && st_s == tsm_pkg::ST_PENDING)
                begin
                    rsp_next.ack_ok     = 1'b1;
                    rsp_next.resv_units = req_reg.hold ? nav_v : nav_reg[s];
                end
            end
            tsm_pkg::CMD_DELAY:
            begin
                if (s_valid)
                begin
                    rsp_next.ack_ok     = 1'b1;
                    rsp_next.slot_state = st_s;
                end
            end
            default:
            begin
                rsp_next.ack_ok     = 1'b1;
                rsp_next.slot_id    = '0;
                rsp_next.slot_state = status_reg[a];
                case (eng_reg)
                    tsm_pkg::EN_IDLE:
                    begin
                        if (due_hit)
                        begin
                            rsp_next.tx_action  = tsm_pkg::ACT_START;
                            rsp_next.slot_id    = 4'(due_idx);
                            rsp_next.slot_state = tsm_pkg::ST_SENDING;
                            rsp_next.tx_phase   = phase_reg[due_idx];
                            rsp_next.tx_ctrl    = scanf_reg[due_idx]
                                ? {4'h1, mode_reg[due_idx][3:0]} : mode_reg[due_idx];
                        end
                    end
                    tsm_pkg::EN_BODY:
                    begin
                        if (body_fail)
                        begin
                            rsp_next.tx_action  = tsm_pkg::ACT_FAIL;
                            rsp_next.slot_id    = 4'(a);
                            rsp_next.slot_state = tsm_pkg::ST_FAIL;
                            rsp_next.tx_phase   = phase_reg[a];
                        end
                        else if (req_reg.tx_byte_taken)
                        begin
                            rsp_next.slot_id  = 4'(a);
                            rsp_next.tx_phase = phase_reg[a];
                            if (sent_reg[a] < len_reg[a])
                            begin
                                rsp_next.tx_action  = tsm_pkg::ACT_BYTE;
                                rsp_next.byte_index = sent_reg[a];
                            end
                            else
                                rsp_next.tx_action = tsm_pkg::ACT_EOP;
                        end
                    end
                    tsm_pkg::EN_EOP:
                    begin
                        if (req_reg.tx_end_done)
                        begin
                            if (eop_last)
                            begin
                                rsp_next.tx_action  = tsm_pkg::ACT_OK;
                                rsp_next.slot_id    = 4'(a);
                                rsp_next.slot_state = tsm_pkg::ST_OKAY;
                                rsp_next.tx_phase   = phase_reg[a];
                            end
                        end
                        else if (wd_over)
                        begin
                            rsp_next.tx_action  = tsm_pkg::ACT_FAIL;
                            rsp_next.slot_id    = 4'(a);
                            rsp_next.slot_state = tsm_pkg::ST_FAIL;
                            rsp_next.tx_phase   = phase_reg[a];
                        end
                    end
                    default:
                    begin
                        if (delay_reg[a] == 16'd0)
                        begin
                            rsp_next.tx_action = tsm_pkg::ACT_START;
                            rsp_next.slot_id   = 4'(a);
                            rsp_next.tx_phase  = phase_reg[a];
                            rsp_next.tx_ctrl   = {4'h1 << order_reg[a], mode_reg[a][3:0]};
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= tsm_pkg::ST_IDLE;
                scanf_reg[i]  <= 1'b0;
                holdf_reg[i]  <= 1'b0;
                delay_reg[i]  <= '0;
                sent_reg[i]   <= '0;
                order_reg[i]  <= '0;
                nav_reg[i]    <= '0;
            end
            eng_reg  <= tsm_pkg::EN_IDLE;
            act_reg  <= '0;
            wd_reg   <= '0;
            busy_reg <= 1'b0;
            rsp_reg  <= '0;
        end
        else if (ctl.load)
        begin
            busy_reg <= 1'b1;
            // age delays first on tick
            if (req.cmd == tsm_pkg::CMD_TICK)
                for (int i = 0; i < SLOTS; i++)
                    if ((status_reg[i] == tsm_pkg::ST_PENDING
                         || status_reg[i] == tsm_pkg::ST_SENDING) && delay_reg[i] != 16'd0)
                        delay_reg[i] <= delay_reg[i] - 16'd1;
        end
        else if (ctl.exec)
        begin
            busy_reg <= 1'b0;
            rsp_reg  <= rsp_next;
            case (req_reg.cmd)
                tsm_pkg::CMD_RESERVE:
                begin
                    if (free_hit || done_hit)
                        status_reg[rsv_idx] <= tsm_pkg::ST_RESERVED;
                end
                tsm_pkg::CMD_PUSH:
                begin
                    if (s_valid && st_s == tsm_pkg::ST_RESERVED)
                    begin
                        if (push_bad)
                            status_reg[s] <= tsm_pkg::ST_IDLE;
                        else
                        begin
                            phase_reg[s]  <= req_reg.phase;
                            mode_reg[s]   <= req_reg.xmode;
                            scanf_reg[s]  <= req_reg.scan;
                            holdf_reg[s]  <= 1'b0;
                            delay_reg[s]  <= req_reg.delay;
                            len_reg[s]    <= req_reg.frame_len;
                            sent_reg[s]   <= '0;
                            order_reg[s]  <= '0;
                            status_reg[s] <= tsm_pkg::ST_PENDING;
                        end
                    end
                end
                tsm_pkg::CMD_READ, tsm_pkg::CMD_PEEK:
                begin
                    if (s_valid && req_reg.cmd == tsm_pkg::CMD_READ
                        && (st_s == tsm_pkg::ST_OKAY || st_s == tsm_pkg::ST_FAIL))
                        status_reg[s] <= tsm_pkg::ST_IDLE;
                end
                tsm_pkg::CMD_CANCEL:
                begin
                    if (s_valid && st_s == tsm_pkg::ST_PENDING)
                        status_reg[s] <= tsm_pkg::ST_FAIL;
                end
                tsm_pkg::CMD_HOLD:
                begin
                    if (s_valid && st_s == tsm_pkg::ST_PENDING)
                    begin
                        if (req_reg.hold)
                        begin
                            nav_reg[s]   <= nav_v;
                            holdf_reg[s] <= 1'b1;
                        end
                        else
                            holdf_reg[s] <= 1'b0;
                    end
                end
                tsm_pkg::CMD_DELAY:
                begin
                    if (s_valid)
                        delay_reg[s] <= req_reg.delay;
                end
                default:
                begin
                    case (eng_reg)
                        tsm_pkg::EN_IDLE:
                        begin
                            if (due_hit)
                            begin
                                act_reg             <= due_idx;
                                status_reg[due_idx] <= tsm_pkg::ST_SENDING;
                                sent_reg[due_idx]   <= 10'd1;
                                wd_reg              <= '0;
                                eng_reg             <= tsm_pkg::EN_BODY;
                            end
                        end
                        tsm_pkg::EN_BODY:
                        begin
                            if (body_fail)
                            begin
                                status_reg[a] <= tsm_pkg::ST_FAIL;
                                eng_reg       <= tsm_pkg::EN_IDLE;
                            end
                            else if (!req_reg.tx_byte_taken)
                                wd_reg <= wd_reg + 14'd1;
                            else
                            begin
                                wd_reg <= '0;
                                if (sent_reg[a] < len_reg[a])
                                    sent_reg[a] <= sent_reg[a] + 10'd1;
                                else
                                    eng_reg <= tsm_pkg::EN_EOP;
                            end
                        end
                        tsm_pkg::EN_EOP:
                        begin
                            if (req_reg.tx_end_done)
                            begin
                                if (eop_last)
                                begin
                                    status_reg[a] <= tsm_pkg::ST_OKAY;
                                    eng_reg       <= tsm_pkg::EN_IDLE;
                                end
                                else
                                begin
                                    order_reg[a] <= order_reg[a] + 2'd1;
                                    delay_reg[a] <= scan_gap_reg;
                                    eng_reg      <= tsm_pkg::EN_GAP;
                                end
                            end
                            else if (wd_over)
                            begin
                                status_reg[a] <= tsm_pkg::ST_FAIL;
                                eng_reg       <= tsm_pkg::EN_IDLE;
                            end
                            else
                                wd_reg <= wd_reg + 14'd1;
                        end
                        default:
                        begin
                            if (delay_reg[a] == 16'd0)
                            begin
                                sent_reg[a] <= 10'd1;
                                eng_reg     <= tsm_pkg::EN_BODY;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            req_reg <= req;
    end

    assign sts.busy = busy_reg;
    assign rsp      = rsp_reg;

`ifndef SYNTHESIS
    a_idle_engine_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_reg != tsm_pkg::EN_IDLE && !busy_reg) |-> status_reg[a] == tsm_pkg::ST_SENDING)
        else $error("active slot not sending");
    a_tick_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && tick) |=> rsp_reg.ack_ok) else $error("tick not acked");
    a_act_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && !tick) |=> rsp_reg.tx_action == tsm_pkg::ACT_NONE)
        else $error("action on non-tick");
`endif

endmodule
